// ----- design/ipdhb_pkg.sv -----
// Package for the frame/HTTP body extractor: character codes, register indexes,
// widths, reset values and the per-item result record.
// No dependencies.
`default_nettype none

package ipdhb_pkg;

  localparam int DEF_MAX_DIGITS  = 7;
  localparam int DEF_OFFSET_BITS = 20;
  localparam int OFFSET_BITS_MAX = 24;

  localparam int CAP_W     = 21;
  localparam int TIMEOUT_W = 16;
  localparam int LEN_W     = 24;
  localparam int CFG_W     = 21;

  localparam logic [CAP_W-1:0]     CAP_RESET     = 21'd1048576;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] HDR_BREAKS = 3'd4;

  typedef enum logic {
    REG_BODY_CAPACITY = 1'b0,
    REG_IDLE_TIMEOUT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                       finished;
    logic [CAP_W-1:0]           body_total;
    logic [OFFSET_BITS_MAX-1:0] body_offset;
    logic [7:0]                 body_byte;
    logic                       body_valid;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ipdhb_parser.sv -----
// Parser state and per-item update for the frame/HTTP body extractor.
// Depends on ipdhb_pkg. State advances on take; res is the item's result.
`default_nettype none

module ipdhb_parser
  import ipdhb_pkg::*;
#(
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic                 func,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [CAP_W-1:0]     body_capacity,
  input  wire logic [TIMEOUT_W-1:0] idle_timeout,
  output result_t                   res
);

  localparam int CMP_W = OFFSET_BITS_MAX + 1;
  localparam logic [CMP_W-1:0] OFF_LIM = CMP_W'(1) << OFFSET_BITS;
  localparam logic [OFFSET_BITS_MAX-1:0] OFF_MASK =
    (OFFSET_BITS_MAX'(1) << OFFSET_BITS) - OFFSET_BITS_MAX'(1);
  localparam logic [2:0] DIGITS_MAX = 3'(MAX_DIGITS);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [2:0]           digit_cnt_r, digit_cnt_nxt;
  logic [LEN_W-1:0]     len_acc_r, len_acc_nxt;
  logic [LEN_W-1:0]     remain_r, remain_nxt;
  logic [2:0]           brk_run_r, brk_run_nxt;
  logic                 hdr_done_r, hdr_done_nxt;
  logic [CAP_W-1:0]     stored_r, stored_nxt;
  logic [TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic                 ended_r, ended_nxt;

  logic [CMP_W-1:0]           cap_ext, cap_eff;
  logic                       store_ok;
  logic [OFFSET_BITS_MAX-1:0] stored_ext;
  logic [3:0]                 digit_val;

  assign cap_ext    = CMP_W'(body_capacity);
  assign cap_eff    = (cap_ext > OFF_LIM) ? OFF_LIM : cap_ext;
  assign store_ok   = CMP_W'(stored_r) < cap_eff;
  assign stored_ext = OFFSET_BITS_MAX'(stored_r);
  assign digit_val  = 4'(rx_byte - CH_ZERO);

  always_comb begin
    phase_nxt          = phase_r;
    digit_cnt_nxt      = digit_cnt_r;
    len_acc_nxt        = len_acc_r;
    remain_nxt         = remain_r;
    brk_run_nxt        = brk_run_r;
    hdr_done_nxt       = hdr_done_r;
    stored_nxt         = stored_r;
    idle_nxt           = idle_r;
    ended_nxt          = ended_r || (idle_r >= idle_timeout);
    res.body_valid     = 1'b0;
    res.body_byte      = 8'd0;
    res.body_offset    = '0;

    if (!ended_nxt) begin
      if (func) begin
        if (idle_r != '1) idle_nxt = idle_r + TIMEOUT_W'(1);
        if (idle_nxt >= idle_timeout) ended_nxt = 1'b1;
      end else begin
        idle_nxt = '0;
        case (phase_r)
          PH_LEN: begin
            if (rx_byte == CH_COLON) begin
              remain_nxt = len_acc_r;
              phase_nxt  = (len_acc_r == '0) ? PH_WAIT : PH_DATA;
            end else if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
              if (digit_cnt_r < DIGITS_MAX) begin
                len_acc_nxt   = (len_acc_r << 3) + (len_acc_r << 1) + LEN_W'(digit_val);
                digit_cnt_nxt = digit_cnt_r + 3'd1;
              end
            end
          end
          PH_DATA: begin
            if (!hdr_done_r) begin
              if (rx_byte inside {CH_CR, CH_LF}) begin
                brk_run_nxt = brk_run_r + 3'd1;
                if (brk_run_nxt >= HDR_BREAKS) begin
                  hdr_done_nxt = 1'b1;
                  brk_run_nxt  = HDR_BREAKS;
                end
              end else begin
                brk_run_nxt = 3'd0;
              end
            end else if (store_ok) begin
              res.body_valid  = 1'b1;
              res.body_byte   = rx_byte;
              res.body_offset = stored_ext & OFF_MASK;
              stored_nxt      = stored_r + CAP_W'(1);
            end
            if (remain_r <= LEN_W'(1)) begin
              remain_nxt = '0;
              phase_nxt  = PH_WAIT;
            end else begin
              remain_nxt = remain_r - LEN_W'(1);
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
            if (rx_byte == CH_PLUS) begin
              digit_cnt_nxt = 3'd0;
              len_acc_nxt   = '0;
              phase_nxt     = PH_LEN;
            end
          end
        endcase
      end
    end

    res.body_total = stored_nxt;
    res.finished   = ended_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      digit_cnt_r <= 3'd0;
      len_acc_r   <= '0;
      remain_r    <= '0;
      brk_run_r   <= 3'd0;
      hdr_done_r  <= 1'b0;
      stored_r    <= '0;
      idle_r      <= '0;
      ended_r     <= 1'b0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      len_acc_r   <= len_acc_nxt;
      remain_r    <= remain_nxt;
      brk_run_r   <= brk_run_nxt;
      hdr_done_r  <= hdr_done_nxt;
      stored_r    <= stored_nxt;
      idle_r      <= idle_nxt;
      ended_r     <= ended_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/ipd_frame_http_body_extractor_core.sv -----
// Extracts the HTTP body from length-prefixed frames in a received byte stream.
// An item is accepted every clock cycle while in_tready is high; its result is
// registered in the output register, or in the skid register if the output
// register is full. This two-entry buffer lets input continue while out_tready
// is low, so the input side only stalls once both entries hold unread results.
// There is no clearing pass after reset. Configuration registers are written
// through the cfg_ port, which is always ready, and must only be changed while
// the block is idle. Depends on ipdhb_pkg and ipdhb_parser.
`default_nettype none

module ipd_frame_http_body_extractor_core
  import ipdhb_pkg::*;
#(
  parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  localparam int OUT_BITS   = 1 + 8 + OFFSET_BITS + CAP_W + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  wire logic             in_tuser,   // [0] func
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // body_valid, body_byte, body_offset, body_total, finished, zero pad
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [CAP_W-1:0]     body_cap_r;
  logic [TIMEOUT_W-1:0] idle_timeout_r;
  logic                 in_acc;
  result_t              res;
  logic [OUT_W-1:0]     res_packed;
  logic                 out_valid_r, skid_valid_r;
  logic [OUT_W-1:0]     out_data_r, skid_data_r;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_cap_r     <= CAP_RESET;
      idle_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BODY_CAPACITY: body_cap_r     <= cfg_data;
        REG_IDLE_TIMEOUT:  idle_timeout_r <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  ipdhb_parser #(
    .MAX_DIGITS  (MAX_DIGITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_acc),
    .func          (in_tuser),
    .rx_byte       (in_tdata),
    .body_capacity (body_cap_r),
    .idle_timeout  (idle_timeout_r),
    .res           (res)
  );

  assign res_packed = OUT_W'({res.finished, res.body_total,
                              res.body_offset[OFFSET_BITS-1:0],
                              res.body_byte, res.body_valid});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_packed;
    end else if (in_acc) begin
      skid_data_r <= res_packed;
    end
  end

endmodule

`default_nettype wire
